/* design/sfxsweep_pkg.sv */
// sfxsweep_pkg: types, codes, sweep constants and the Hz conversion shared by
// the sound effect sweep sequencer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfxsweep_pkg;

    localparam int SLOT_COUNT = 3;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam int PADDR_W = 3;
    localparam logic REG_SOUND_ENABLE = 1'b0;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_CLEAR = 3'd3,
        OP_FRAME = 3'd4,
        OP_HUSH  = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_DOT_DOWN = 3'd1,
        KIND_DOT_UP   = 3'd2,
        KIND_GHOST    = 3'd3,
        KIND_FRUIT    = 3'd4,
        KIND_SIREN    = 3'd5,
        KIND_FRIGHT   = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK,
        ST_CONV,
        ST_EMIT
    } state_t;

    typedef logic [SLOT_W-1:0] slot_addr_t;

    // controller to datapath
    typedef struct packed {
        logic       capture;
        logic       start;
        logic       stop;
        logic       clear;
        logic       tick;
        logic       conv;
        logic       emit_frame;
        logic       emit_hush;
        slot_addr_t slot;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } status_t;

    // sweep constants
    localparam logic [15:0] DOT_DOWN_START = 16'h1500;
    localparam logic [15:0] DOT_UP_START   = 16'h0700;
    localparam logic [15:0] DOT_STEP       = 16'h0300;
    localparam logic [15:0] GHOST_STEP     = 16'h0020;
    localparam logic [15:0] FRUIT_START    = 16'h1600;
    localparam logic [15:0] FRUIT_STEP     = 16'h0200;
    localparam logic [15:0] SIREN_START    = 16'h1000;
    localparam logic [15:0] SIREN_STEP     = 16'h0200;
    localparam logic [15:0] FRIGHT_STEP    = 16'h0180;

    localparam logic [15:0] DOT_END    = 16'd5;
    localparam logic [15:0] GHOST_END  = 16'd32;
    localparam logic [15:0] FRUIT_END  = 16'd23;
    localparam logic [15:0] FRUIT_TURN = 16'd11;

    localparam logic [4:0] PHASE_WRAP = 5'd24;
    localparam logic [4:0] PHASE_HALF = 5'd12;

    localparam logic [3:0] VOL_DOT    = 4'd12;
    localparam logic [3:0] VOL_FRUIT  = 4'd15;
    localparam logic [3:0] VOL_SIREN  = 4'd6;
    localparam logic [3:0] VOL_FRIGHT = 4'd10;

    localparam logic [16:0] HZ_MULT = 17'd47;
    localparam logic [11:0] HZ_MAX  = 12'hFFF;

    localparam logic [1:0] HOLD_FRAME = 2'd2;
    localparam logic [1:0] HOLD_HUSH  = 2'd0;

    // raw voice frequency to speaker Hz: ((f >> 5) * 47) >> 4
    function automatic logic [12:0] to_hz(input logic [15:0] f);
        logic [16:0] prod;
        begin
            prod = 17'(f[15:5]) * HZ_MULT;
            return prod[16:4];
        end
    endfunction

endpackage

`default_nettype wire

/* design/sfxsweep_in_if.sv */
// sfxsweep_in_if: request channel of the sweep sequencer (valid/ready + op).
// Uses nothing else.
`timescale 1ns / 1ps
`default_nettype none

interface sfxsweep_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [1:0] slot_index;
    logic [2:0] effect_kind;

    modport source (output valid, output op, output slot_index, output effect_kind,
                    input ready);
    modport sink   (input valid, input op, input slot_index, input effect_kind,
                    output ready);
endinterface

`default_nettype wire

/* design/sfxsweep_out_if.sv */
// sfxsweep_out_if: result channel of the sweep sequencer (valid/ready + tone).
// Uses nothing else.
`timescale 1ns / 1ps
`default_nettype none

interface sfxsweep_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] tone_hz;
    logic [1:0]  hold_ticks;

    modport source (output valid, output tone_hz, output hold_ticks, input ready);
    modport sink   (input valid, input tone_hz, input hold_ticks, output ready);
endinterface

`default_nettype wire

/* design/sfxsweep_ctrl.sv */
// sfxsweep_ctrl: sequencing state machine; walks the slots on a tick and
// orders the frame/hush result. Depends on sfxsweep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfxsweep_ctrl
    import sfxsweep_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [2:0] op,
    output logic            in_ready,
    input  wire status_t    status,
    output cmd_t            cmd
);

    state_t     state_reg, state_next;
    logic [2:0] op_reg, op_next;
    slot_addr_t slot_cnt_reg, slot_cnt_next;
    logic       in_fire;
    logic       last_slot;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign last_slot = (slot_cnt_reg == SLOT_W'(SLOT_COUNT - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (op)
                        OP_TICK:                     state_next = ST_TICK;
                        OP_START, OP_STOP, OP_CLEAR: state_next = ST_EXEC;
                        OP_FRAME:                    state_next = ST_CONV;
                        OP_HUSH:                     state_next = ST_EMIT;
                        default:                     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EXEC: state_next = ST_IDLE;
            ST_TICK:
            begin
                if (last_slot)
                    state_next = ST_IDLE;
            end
            ST_CONV: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // op latch and slot walk counter
    always_comb
    begin
        op_next       = op_reg;
        slot_cnt_next = slot_cnt_reg;
        if (in_fire)
        begin
            op_next       = op;
            slot_cnt_next = '0;
        end
        else if (state_reg == ST_TICK && !last_slot)
        begin
            slot_cnt_next = slot_cnt_reg + SLOT_W'(1);
        end
    end

    // commands
    always_comb
    begin
        cmd         = '0;
        cmd.capture = in_fire;
        cmd.slot    = slot_cnt_reg;
        unique case (state_reg)
            ST_EXEC:
            begin
                cmd.start = (op_reg == OP_START);
                cmd.stop  = (op_reg == OP_STOP);
                cmd.clear = (op_reg == OP_CLEAR);
            end
            ST_TICK: cmd.tick = 1'b1;
            ST_CONV: cmd.conv = 1'b1;
            ST_EMIT:
            begin
                cmd.emit_frame = (op_reg == OP_FRAME);
                cmd.emit_hush  = (op_reg == OP_HUSH);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            op_reg       <= 3'(OP_TICK);
            slot_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            slot_cnt_reg <= slot_cnt_next;
        end
    end

    a_tick_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TICK && last_slot) |=> (state_reg == ST_IDLE))
        else $error("tick walk did not end after the last slot");

    a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !status.out_free) |=> (state_reg == ST_EMIT))
        else $error("left emit while the result register was full");

endmodule

`default_nettype wire

/* design/sfxsweep_dp.sv */
// sfxsweep_dp: slot store, voice registers, sweep step, Hz conversion and the
// result register. Depends on sfxsweep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfxsweep_dp
    import sfxsweep_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    input  wire logic [1:0]  slot_index,
    input  wire logic [2:0]  effect_kind,
    input  wire logic        sound_enable,
    output status_t          status,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [11:0]      tone_hz,
    output logic [1:0]       hold_ticks
);

    kind_t       slot_kind_reg [SLOT_COUNT];
    logic [15:0] slot_tick_reg [SLOT_COUNT];

    logic [1:0]  slot_in_reg;
    logic [2:0]  kind_in_reg;

    logic [15:0] eff_freq_reg, eff_freq_next;
    logic [3:0]  eff_vol_reg,  eff_vol_next;
    logic [15:0] tune_freq_reg, tune_freq_next;
    logic [3:0]  tune_vol_reg,  tune_vol_next;
    logic [4:0]  phase_reg, phase_next;
    logic        last_nz_reg, last_nz_next;
    logic [12:0] pick_hz_reg, pick_hz_next;

    logic        out_valid_reg, out_valid_next;
    logic [11:0] tone_reg, tone_next;
    logic [1:0]  hold_reg, hold_next;

    slot_addr_t  addr;
    logic        in_range;
    kind_t       kind_rd;
    logic [15:0] tick_rd;
    logic        slot_we;
    kind_t       kind_wr;
    logic [15:0] tick_wr;
    logic [4:0]  phase_inc;
    logic [12:0] eff_hz, tune_hz;
    logic        out_free;

    assign addr     = cmd.tick ? cmd.slot : SLOT_W'(slot_in_reg);
    assign in_range = (32'(slot_in_reg) < 32'(SLOT_COUNT));
    assign kind_rd  = slot_kind_reg[addr];
    assign tick_rd  = slot_tick_reg[addr];
    assign phase_inc = phase_reg + 5'd1;

    assign out_free        = !out_valid_reg || out_ready;
    assign status.out_free = out_free;

    // slot step, start, stop and clear
    always_comb
    begin
        slot_we        = 1'b0;
        kind_wr        = kind_rd;
        tick_wr        = tick_rd + 16'd1;
        eff_freq_next  = eff_freq_reg;
        eff_vol_next   = eff_vol_reg;
        tune_freq_next = tune_freq_reg;
        tune_vol_next  = tune_vol_reg;
        phase_next     = phase_reg;

        if (cmd.tick)
        begin
            unique case (kind_rd)
                KIND_DOT_DOWN, KIND_DOT_UP:
                begin
                    slot_we = 1'b1;
                    if (tick_rd == DOT_END)
                    begin
                        kind_wr       = KIND_NONE;
                        tick_wr       = '0;
                        eff_freq_next = '0;
                        eff_vol_next  = '0;
                    end
                    else
                    begin
                        eff_vol_next = VOL_DOT;
                        if (kind_rd == KIND_DOT_DOWN)
                            eff_freq_next = (tick_rd == '0) ? DOT_DOWN_START
                                                            : eff_freq_reg - DOT_STEP;
                        else
                            eff_freq_next = (tick_rd == '0) ? DOT_UP_START
                                                            : eff_freq_reg + DOT_STEP;
                    end
                end
                KIND_GHOST:
                begin
                    slot_we = 1'b1;
                    if (tick_rd == GHOST_END)
                    begin
                        kind_wr       = KIND_NONE;
                        tick_wr       = '0;
                        eff_freq_next = '0;
                        eff_vol_next  = '0;
                    end
                    else
                    begin
                        eff_vol_next  = VOL_DOT;
                        eff_freq_next = (tick_rd == '0) ? 16'h0000 : eff_freq_reg + GHOST_STEP;
                    end
                end
                KIND_FRUIT:
                begin
                    slot_we = 1'b1;
                    if (tick_rd == FRUIT_END)
                    begin
                        kind_wr       = KIND_NONE;
                        tick_wr       = '0;
                        eff_freq_next = '0;
                        eff_vol_next  = '0;
                    end
                    else
                    begin
                        eff_vol_next = VOL_FRUIT;
                        priority if (tick_rd == '0)
                            eff_freq_next = FRUIT_START;
                        else if (tick_rd < FRUIT_TURN)
                            eff_freq_next = eff_freq_reg - FRUIT_STEP;
                        else
                            eff_freq_next = eff_freq_reg + FRUIT_STEP;
                    end
                end
                KIND_SIREN:
                begin
                    slot_we       = 1'b1;
                    tune_vol_next = VOL_SIREN;
                    if (tick_rd == '0)
                    begin
                        tune_freq_next = SIREN_START;
                        phase_next     = '0;
                    end
                    else
                    begin
                        phase_next = (phase_inc >= PHASE_WRAP) ? 5'd0 : phase_inc;
                        if (phase_next < PHASE_HALF)
                            tune_freq_next = tune_freq_reg + SIREN_STEP;
                        else
                            tune_freq_next = tune_freq_reg - SIREN_STEP;
                    end
                end
                KIND_FRIGHT:
                begin
                    slot_we        = 1'b1;
                    tune_vol_next  = VOL_FRIGHT;
                    tune_freq_next = (tick_rd[2:0] == 3'd0) ? FRIGHT_STEP
                                                            : tune_freq_reg + FRIGHT_STEP;
                end
                default: ;
            endcase
        end
        else if (cmd.start && in_range)
        begin
            slot_we = 1'b1;
            kind_wr = (kind_in_reg <= 3'(KIND_FRIGHT)) ? kind_t'(kind_in_reg) : KIND_NONE;
            tick_wr = '0;
        end
        else if (cmd.stop && in_range)
        begin
            slot_we = 1'b1;
            kind_wr = KIND_NONE;
            tick_wr = '0;
            unique case (kind_rd)
                KIND_DOT_DOWN, KIND_DOT_UP, KIND_GHOST, KIND_FRUIT:
                begin
                    eff_freq_next = '0;
                    eff_vol_next  = '0;
                end
                KIND_SIREN, KIND_FRIGHT:
                begin
                    tune_freq_next = '0;
                    tune_vol_next  = '0;
                end
                default: ;
            endcase
        end
        else if (cmd.clear)
        begin
            eff_freq_next  = '0;
            eff_vol_next   = '0;
            tune_freq_next = '0;
            tune_vol_next  = '0;
        end
    end

    // frame pick and result load
    assign eff_hz  = to_hz(eff_freq_reg);
    assign tune_hz = to_hz(tune_freq_reg);

    always_comb
    begin
        pick_hz_next   = pick_hz_reg;
        last_nz_next   = last_nz_reg;
        out_valid_next = out_valid_reg && !out_ready;
        tone_next      = tone_reg;
        hold_next      = hold_reg;

        if (cmd.conv)
        begin
            priority if (!sound_enable)
                pick_hz_next = '0;
            else if (eff_vol_reg != '0 && eff_hz != '0)
                pick_hz_next = eff_hz;
            else if (tune_vol_reg != '0 && tune_hz != '0)
                pick_hz_next = tune_hz;
            else
                pick_hz_next = '0;
        end

        if (out_free)
        begin
            if (cmd.emit_frame && (pick_hz_reg != '0 || last_nz_reg))
            begin
                out_valid_next = 1'b1;
                tone_next      = (pick_hz_reg > 13'(HZ_MAX)) ? HZ_MAX : pick_hz_reg[11:0];
                hold_next      = HOLD_FRAME;
                last_nz_next   = (pick_hz_reg != '0);
            end
            else if (cmd.emit_hush && last_nz_reg)
            begin
                out_valid_next = 1'b1;
                tone_next      = '0;
                hold_next      = HOLD_HUSH;
                last_nz_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_kind_reg[i] <= KIND_NONE;
                slot_tick_reg[i] <= '0;
            end
            eff_freq_reg  <= '0;
            eff_vol_reg   <= '0;
            tune_freq_reg <= '0;
            tune_vol_reg  <= '0;
            phase_reg     <= '0;
            last_nz_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    slot_kind_reg[i] <= KIND_NONE;
                    slot_tick_reg[i] <= '0;
                end
            end
            else if (slot_we)
            begin
                slot_kind_reg[addr] <= kind_wr;
                slot_tick_reg[addr] <= tick_wr;
            end
            eff_freq_reg  <= eff_freq_next;
            eff_vol_reg   <= eff_vol_next;
            tune_freq_reg <= tune_freq_next;
            tune_vol_reg  <= tune_vol_next;
            phase_reg     <= phase_next;
            last_nz_reg   <= last_nz_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            slot_in_reg <= slot_index;
            kind_in_reg <= effect_kind;
        end
        pick_hz_reg <= pick_hz_next;
        tone_reg    <= tone_next;
        hold_reg    <= hold_next;
    end

    assign out_valid  = out_valid_reg;
    assign tone_hz    = tone_reg;
    assign hold_ticks = hold_reg;

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg < PHASE_WRAP)
        else $error("siren phase out of range");

    a_hush_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && hold_reg == HOLD_HUSH) |-> (tone_reg == '0))
        else $error("hush result carries a tone");

    a_idle_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_kind_reg[0] == KIND_NONE) |-> (slot_tick_reg[0] == '0))
        else $error("idle slot holds a tick count");

endmodule

`default_nettype wire

/* design/sound_effect_sweep_sequencer.sv */
// sound_effect_sweep_sequencer: top level; APB register, request/result
// channels. Depends on sfxsweep_pkg, the two channel interfaces, ctrl and dp.
`timescale 1ns / 1ps
`default_nettype none

// Three effect slots drive an effect voice and a tune voice through fixed
// frequency sweeps. One request is handled at a time. On a tick request the
// controller walks the slots one per cycle through the single read port of
// the slot store, so later slots see the voice values left by earlier ones.
// Start, stop and clear go through accept and execute. Frame goes through
// accept, Hz conversion with the x47 multiply and result load, hush through
// accept and result load; both wait further while the result register is
// still full. Unknown ops are dropped in the accept cycle. The result register
// sits between the core and the result channel. sound_enable lives at APB
// byte addresses 0-3 (reset 1); writes to 4-7 are ignored and read back 0.
module sound_effect_sweep_sequencer
    import sfxsweep_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    sfxsweep_in_if.sink             item,
    sfxsweep_out_if.source          result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic    sound_enable_reg, sound_enable_next;
    logic    reg_hit;
    cmd_t    cmd;
    status_t status;

    // APB: single register, writes take effect at the access phase
    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_SOUND_ENABLE);
    assign prdata  = reg_hit ? {31'b0, sound_enable_reg} : 32'b0;

    always_comb
    begin
        sound_enable_next = sound_enable_reg;
        if (psel && penable && pwrite && pready && reg_hit)
            sound_enable_next = pwdata[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sound_enable_reg <= 1'b1;
        else
            sound_enable_reg <= sound_enable_next;
    end

    sfxsweep_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .op       (item.op),
        .in_ready (item.ready),
        .status   (status),
        .cmd      (cmd)
    );

    sfxsweep_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .slot_index   (item.slot_index),
        .effect_kind  (item.effect_kind),
        .sound_enable (sound_enable_reg),
        .status       (status),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .tone_hz      (result.tone_hz),
        .hold_ticks   (result.hold_ticks)
    );

endmodule

`default_nettype wire

/* test/tb_top.sv */
// tb_top: self-checking bench for sound_effect_sweep_sequencer. Requests go in,
// tones come out, and a behavioural sweep model predicts every tone.
// Depends on sfxsweep_pkg, sfxsweep_in_if, sfxsweep_out_if and the design.
`timescale 1ns / 1ps

module tb_top;
    import sfxsweep_pkg::*;

    // Codes the package has no names for
    localparam logic [2:0] OP_SPARE_LO  = 3'd6;     // unknown ops, dropped by the block
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;
    localparam logic [2:0] KIND_INVALID = 3'd7;     // start stores "none" for this one
    localparam logic [1:0] SLOT_UNUSED  = 2'd3;     // beyond the three slots

    localparam logic [PADDR_W-1:0] ADDR_SOUND_ENABLE = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED     = 3'd4;

    localparam logic [1:0] HOLD_FROM_FRAME = 2'd2;
    localparam logic [1:0] HOLD_FROM_HUSH  = 2'd0;
    localparam int         TONE_CEILING    = 4095;

    // A tick walks all slots in turn; allow a good margin before touching
    // the register or ending the run.
    localparam int SETTLE_CYCLES = 12;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [11:0] tone_hz;
        logic [1:0]  hold_ticks;
    } tone_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    wire  [31:0] prdata;
    wire         pready;

    sfxsweep_in_if  in_ch ();
    sfxsweep_out_if out_ch ();

    sound_effect_sweep_sequencer u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (in_ch),
        .result  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Sweep model: our own copy of slot and voice state, advanced once per
    // accepted request. Tones it predicts wait in expected_tones.
    // ------------------------------------------------------------------
    logic        sound_en = 1'b1;
    logic [2:0]  slot_kind [SLOT_COUNT] = '{default: '0};
    logic [15:0] slot_tick [SLOT_COUNT] = '{default: '0};
    logic [15:0] tune_raw   = '0;
    logic [3:0]  tune_vol   = '0;
    logic [15:0] effect_raw = '0;
    logic [3:0]  effect_vol = '0;
    logic [4:0]  siren_phase = '0;
    logic [15:0] last_hz    = '0;       // unsaturated Hz last reported

    tone_t expected_tones [$];
    int    tone_mismatches = 0;

    // sender pacing
    int burst_left    = 0;
    bit steady_sender = 1'b0;

    function automatic int speaker_hz(input logic [15:0] raw);
        return ((raw >> 5) * 47) >> 4;
    endfunction

    // Free a slot; effect kinds silence the effect voice, siren/fright the tune.
    function automatic void silence_slot(input int s);
        if (slot_kind[s] >= KIND_DOT_DOWN && slot_kind[s] <= KIND_FRUIT) begin
            effect_raw = '0;
            effect_vol = '0;
        end else if (slot_kind[s] == KIND_SIREN || slot_kind[s] == KIND_FRIGHT) begin
            tune_raw = '0;
            tune_vol = '0;
        end
        slot_kind[s] = KIND_NONE;
        slot_tick[s] = '0;
    endfunction

    // One tick: slots in index order, so later slots see earlier voice writes.
    function automatic void step_slots();
        logic [15:0] t;
        logic        ends;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            t    = slot_tick[s];
            ends = 1'b0;
            case (slot_kind[s])
                KIND_DOT_DOWN: begin
                    ends = (t == 16'd5);
                    if (!ends) begin
                        effect_raw = (t == 16'd0) ? 16'h1500 : effect_raw - 16'h0300;
                        effect_vol = 4'd12;
                    end
                end
                KIND_DOT_UP: begin
                    ends = (t == 16'd5);
                    if (!ends) begin
                        effect_raw = (t == 16'd0) ? 16'h0700 : effect_raw + 16'h0300;
                        effect_vol = 4'd12;
                    end
                end
                KIND_GHOST: begin
                    ends = (t == 16'd32);
                    if (!ends) begin
                        effect_raw = (t == 16'd0) ? 16'h0000 : effect_raw + 16'h0020;
                        effect_vol = 4'd12;
                    end
                end
                KIND_FRUIT: begin
                    ends = (t == 16'd23);
                    if (!ends) begin
                        if (t == 16'd0)
                            effect_raw = 16'h1600;
                        else if (t < 16'd11)
                            effect_raw = effect_raw - 16'h0200;
                        else
                            effect_raw = effect_raw + 16'h0200;
                        effect_vol = 4'd15;
                    end
                end
                KIND_SIREN: begin
                    // never ends; the phase runs 0..23 and flips direction at 12
                    if (t == 16'd0) begin
                        tune_raw    = 16'h1000;
                        siren_phase = '0;
                    end else begin
                        siren_phase = (siren_phase >= 5'd23) ? 5'd0 : siren_phase + 5'd1;
                        tune_raw    = (siren_phase < 5'd12) ? tune_raw + 16'h0200
                                                            : tune_raw - 16'h0200;
                    end
                    tune_vol = 4'd6;
                end
                KIND_FRIGHT: begin
                    tune_raw = (t[2:0] == 3'd0) ? 16'h0180 : tune_raw + 16'h0180;
                    tune_vol = 4'd10;
                end
                default: ;
            endcase
            if (ends)
                silence_slot(s);
            else if (slot_kind[s] != KIND_NONE)
                slot_tick[s] = t + 16'd1;     // wraps at 2^16
        end
    endfunction

    function automatic void advance_sound_model(input logic [2:0] op,
                                                input logic [1:0] slot,
                                                input logic [2:0] kind);
        int eff_hz;
        int tun_hz;
        int hz;
        tone_t tone;
        case (op)
            OP_TICK:  step_slots();
            OP_START: begin
                if (slot < SLOT_COUNT) begin
                    slot_kind[slot] = (kind == KIND_INVALID) ? 3'(KIND_NONE) : kind;
                    slot_tick[slot] = '0;
                end
            end
            OP_STOP: begin
                if (slot < SLOT_COUNT)
                    silence_slot(int'(slot));
            end
            OP_CLEAR: begin
                // phase and last reported Hz survive a clear
                for (int s = 0; s < SLOT_COUNT; s++) begin
                    slot_kind[s] = KIND_NONE;
                    slot_tick[s] = '0;
                end
                effect_raw = '0;
                effect_vol = '0;
                tune_raw   = '0;
                tune_vol   = '0;
            end
            OP_FRAME: begin
                hz = 0;
                if (sound_en) begin
                    eff_hz = speaker_hz(effect_raw);
                    tun_hz = speaker_hz(tune_raw);
                    if (effect_vol != 0 && eff_hz != 0)
                        hz = eff_hz;
                    else if (tune_vol != 0 && tun_hz != 0)
                        hz = tun_hz;
                end
                // silence is only reported once, as a change from a tone
                if (hz != 0 || last_hz != 0) begin
                    last_hz         = hz[15:0];
                    tone.tone_hz    = (hz > TONE_CEILING) ? 12'(TONE_CEILING) : hz[11:0];
                    tone.hold_ticks = HOLD_FROM_FRAME;
                    expected_tones.push_back(tone);
                end
            end
            OP_HUSH: begin
                if (last_hz != 0) begin
                    last_hz         = '0;
                    tone.tone_hz    = '0;
                    tone.hold_ticks = HOLD_FROM_HUSH;
                    expected_tones.push_back(tone);
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock, timeout
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Slowest correct run is well under 5 ms; this is several times that.
    initial
    begin
        #25_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: the receiver stalls on a rotating bit pattern, reloaded
    // now and then; roughly a quarter of the windows never stall.
    // ------------------------------------------------------------------
    initial
    begin : result_stall
        logic [31:0] stall_bits;
        int          window;
        stall_bits = '1;
        window     = 0;
        out_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (window == 0)
            begin
                window = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0:       stall_bits = '1;
                    1:       stall_bits = $urandom | $urandom;
                    default: stall_bits = $urandom;
                endcase
            end
            window--;
            stall_bits = {stall_bits[0], stall_bits[31:1]};
            out_ch.ready <= stall_bits[0];
        end
    end

    // Each tone taken is compared with the oldest prediction.
    always @(posedge clk)
    begin : tone_check
        tone_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_tones.size() == 0)
            begin
                tone_mismatches++;
                if (tone_mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected tone %0d hold %0d", $realtime,
                             out_ch.tone_hz, out_ch.hold_ticks);
            end
            else
            begin
                want = expected_tones.pop_front();
                if (out_ch.tone_hz !== want.tone_hz || out_ch.hold_ticks !== want.hold_ticks)
                begin
                    tone_mismatches++;
                    if (tone_mismatches <= REPORT_LIMIT)
                        $display("%0t: tone expected %0d hold %0d, got %0d hold %0d",
                                 $realtime, want.tone_hz, want.hold_ticks,
                                 out_ch.tone_hz, out_ch.hold_ticks);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One request. Outside steady stretches the sender runs in bursts with
    // random gaps. valid stays up after acceptance so back-to-back requests
    // see no bubble; whoever goes idle lowers it.
    task automatic issue_request(input logic [2:0] op, input logic [1:0] slot,
                                 input logic [2:0] kind);
        int gap;
        if (!steady_sender)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(0, 7);
                if (gap != 0)
                begin
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 20);
            end
            burst_left--;
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= op;
        in_ch.slot_index  <= slot;
        in_ch.effect_kind <= kind;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        advance_sound_model(op, slot, kind);
    endtask

    // Sender pauses until every predicted tone is out and the block is idle.
    task automatic drain_tones();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_tones.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup then access; ends on an idle cycle so calls may follow.
    task automatic write_apb(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_SOUND_ENABLE)
            sound_en = data[0];
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every op and the corner cases, one request each.
    task automatic test_directed_cases();
        write_apb(ADDR_SOUND_ENABLE, 32'h0000_0001);
        write_apb(ADDR_UNMAPPED, 32'hFFFF_FFFE);            // ignored
        issue_request(OP_FRAME, 2'd0, KIND_NONE);            // nothing to report yet
        issue_request(OP_HUSH, SLOT_UNUSED, KIND_INVALID);   // hush when already quiet
        issue_request(OP_START, SLOT_UNUSED, KIND_DOT_UP);   // slot out of range
        issue_request(OP_START, 2'd1, KIND_DOT_DOWN);
        issue_request(OP_TICK, 2'd0, KIND_NONE);
        issue_request(OP_START, 2'd0, KIND_GHOST);
        // ghost zeroes the effect voice, then dot down subtracts: raw wraps
        issue_request(OP_TICK, 2'd0, KIND_NONE);
        issue_request(OP_FRAME, 2'd2, KIND_NONE);            // saturates at the ceiling
        issue_request(OP_START, 2'd2, KIND_SIREN);
        issue_request(OP_START, 2'd1, KIND_INVALID);         // kind stored as none
        issue_request(OP_TICK, 2'd0, KIND_NONE);
        issue_request(OP_STOP, 2'd0, KIND_NONE);             // effect voice volume 0
        issue_request(OP_FRAME, 2'd0, KIND_NONE);            // falls back to the tune
        issue_request(OP_SPARE_LO, 2'd1, KIND_FRIGHT);
        issue_request(OP_SPARE_HI, SLOT_UNUSED, KIND_INVALID);
        issue_request(OP_STOP, 2'd1, KIND_NONE);             // stop on an idle slot
        issue_request(OP_START, 2'd0, KIND_GHOST);
        issue_request(OP_TICK, 2'd0, KIND_NONE);             // effect at 0 Hz, audible vol
        issue_request(OP_FRAME, 2'd0, KIND_NONE);
        issue_request(OP_START, 2'd0, KIND_FRIGHT);
        issue_request(OP_TICK, 2'd0, KIND_NONE);
        issue_request(OP_HUSH, 2'd0, KIND_NONE);
        issue_request(OP_FRAME, 2'd0, KIND_NONE);
        issue_request(OP_STOP, SLOT_UNUSED, KIND_NONE);
        issue_request(OP_CLEAR, 2'd0, KIND_NONE);
        issue_request(OP_FRAME, 2'd0, KIND_NONE);            // silence reported once
        issue_request(OP_FRAME, 2'd0, KIND_NONE);            // ... and not again
        drain_tones();
    endtask

    // sound_enable off forces silence; upper data bits must not matter.
    task automatic test_sound_enable();
        write_apb(ADDR_SOUND_ENABLE, 32'h0000_0001);
        issue_request(OP_START, 2'd2, KIND_SIREN);
        issue_request(OP_TICK, 2'd0, KIND_NONE);
        issue_request(OP_FRAME, 2'd0, KIND_NONE);
        drain_tones();
        write_apb(ADDR_SOUND_ENABLE, 32'hFFFF_FFFE);
        issue_request(OP_FRAME, 2'd0, KIND_NONE);
        issue_request(OP_FRAME, 2'd0, KIND_NONE);
        drain_tones();
        write_apb(ADDR_SOUND_ENABLE, 32'hFFFF_FFFF);
        issue_request(OP_FRAME, 2'd0, KIND_NONE);
        issue_request(OP_CLEAR, 2'd0, KIND_NONE);
        issue_request(OP_FRAME, 2'd0, KIND_NONE);
        drain_tones();
    endtask

    // Every kind run through to its end (siren and fright never end; the siren
    // runs past a wrap of its phase), with a second kind in another slot sharing the voices.
    task automatic test_sweep_lifetimes();
        logic [2:0] kinds [6];
        int         lengths [6];
        logic [1:0] slot;
        kinds   = '{KIND_DOT_DOWN, KIND_DOT_UP, KIND_GHOST, KIND_FRUIT,
                    KIND_SIREN, KIND_FRIGHT};
        lengths = '{7, 7, 34, 25, 30, 20};
        for (int i = 0; i < 6; i++)
        begin
            slot = 2'($urandom_range(0, 2));
            issue_request(OP_START, slot, kinds[i]);
            repeat (lengths[i])
            begin
                issue_request(OP_TICK, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
                issue_request(OP_FRAME, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
            end
            // overlap: this kind and a neighbour at once
            issue_request(OP_START, slot, kinds[i]);
            issue_request(OP_START, (slot == 2'd2) ? 2'd0 : slot + 2'd1, kinds[(i + 2) % 6]);
            repeat (lengths[i])
            begin
                issue_request(OP_TICK, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
                issue_request(OP_FRAME, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
            end
            issue_request(OP_CLEAR, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
        end
        drain_tones();
    endtask

    // Weighted random traffic in phases; the register changes between them.
    task automatic test_random_traffic();
        int          pick;
        logic [2:0]  op;
        logic [1:0]  slot;
        logic [2:0]  kind;
        logic [31:0] cfg;
        for (int phase = 0; phase < 6; phase++)
        begin
            drain_tones();
            cfg    = $urandom;
            cfg[0] = !(phase == 1 || phase == 4);
            write_apb(ADDR_SOUND_ENABLE, cfg);
            if (phase == 3)
                write_apb(ADDR_UNMAPPED, $urandom);
            steady_sender = ($urandom_range(0, 3) == 0);
            repeat (140)
            begin
                pick = $urandom_range(0, 99);
                slot = 2'($urandom_range(0, 3));
                kind = 3'($urandom_range(0, 7));
                if (pick < 45)
                    op = OP_TICK;
                else if (pick < 70)
                    op = OP_FRAME;
                else if (pick < 80)
                begin
                    op   = OP_START;
                    slot = 2'($urandom_range(0, 2));
                    kind = 3'($urandom_range(1, 6));
                end
                else if (pick < 83)
                    op = OP_START;          // any slot, any kind
                else if (pick < 88)
                    op = OP_STOP;
                else if (pick < 94)
                    op = OP_HUSH;
                else if (pick < 96)
                    op = OP_CLEAR;
                else if (pick < 98)
                    op = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
                else
                    op = OP_FRAME;
                issue_request(op, slot, kind);
            end
        end
        steady_sender = 1'b0;
        drain_tones();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.op          <= OP_TICK;
        in_ch.slot_index  <= '0;
        in_ch.effect_kind <= KIND_NONE;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= ADDR_SOUND_ENABLE;
        pwdata            <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_sound_enable();
        test_sweep_lifetimes();
        test_random_traffic();

        drain_tones();
        if (tone_mismatches == 0 && expected_tones.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
